// ===== sv/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the bilinear RGB565 scaler.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int MAX_SRC_W  = 256;
    localparam int MAX_SRC_H  = 256;
    localparam int MAX_DST    = 512;
    localparam int PIXEL_BITS = 16;

    localparam int SW_BITS    = $clog2(MAX_SRC_W + 1);
    localparam int SH_BITS    = $clog2(MAX_SRC_H + 1);
    localparam int DST_BITS   = $clog2(MAX_DST + 1);
    localparam int DEPTH      = MAX_SRC_W * MAX_SRC_H;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int STEP_BITS  = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_PRODUCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COORD,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_BLEND1,
        ST_BLEND2,
        ST_DONE
    } state_t;

    // Effective sizes, step ratios and their valid flag handed from the configuration block to the datapath.
    typedef struct packed {
        logic [SW_BITS-1:0]   sw;
        logic [SH_BITS-1:0]   sh;
        logic [DST_BITS-1:0]  dw;
        logic [DST_BITS-1:0]  dh;
        logic [STEP_BITS-1:0] x_step;
        logic [STEP_BITS-1:0] y_step;
        logic                 steps_ok;
    } geom_t;

endpackage

// ===== sv/rgb565_bilinear_scaler.sv =====
// ----------------------------------------------------------------------------
// rgb565_bilinear_scaler
// Bilinear RGB565 scaler around a single-port frame store.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A store beat
// (operation 0) writes pixel_in at (col, row) of the source frame and gives
// no result; busy stays low. A produce beat (operation 1) returns one pixel
// on pixel_out and out_of_range, marked by done for exactly one cycle. An
// in-range produce goes from accept to done through a coordinate state, four
// single-port reads of the frame memory, two states for the blend multiplies,
// one final state and the registered strobe. An out-of-range produce goes
// from the coordinate state straight to the final state.
// The receiver cannot stall, so results never wait.
// Configuration writes on cfg_we/cfg_index/cfg_data restart a serial divider
// that computes the x and then the y step ratio; busy is high meanwhile,
// also after reset. The frame store is not cleared at reset: pixels must be
// stored before they are read.
// ----------------------------------------------------------------------------
module rgb565_bilinear_scaler
    import rbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic [8:0]               col,
    input  logic [8:0]               row,
    input  logic [PIXEL_BITS-1:0]    pixel_in,
    output logic                     done,
    output logic [PIXEL_BITS-1:0]    pixel_out,
    output logic                     out_of_range
);

    geom_t geom;
    state_t state_reg, state_next;

    logic [8:0] col_reg, row_reg;
    logic [ADDR_BITS+1:0] base0_reg, base1_reg;
    logic [SW_BITS-1:0]   x_reg, xn_reg;
    logic [7:0] xw_reg, yw_reg;
    logic [PIXEL_BITS-1:0] p1_reg, p2_reg, p3_reg;
    logic [12:0] top_r_reg, bot_r_reg, top_b_reg, bot_b_reg;
    logic [13:0] top_g_reg, bot_g_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic oor_reg, done_reg;

    logic accept;
    logic ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [PIXEL_BITS-1:0] ram_rdata;

    rbs_step_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    assign busy   = (state_reg != ST_IDLE) || !geom.steps_ok;
    assign accept = start && !busy;

    // Coordinate arithmetic (COORD state).
    logic [32:0] xp, yp;
    logic [16:0] xi, yi;
    logic [SW_BITS-1:0] xc, xnc;
    logic [SH_BITS-1:0] yc, ync;
    assign xp = 33'(col_reg) * 33'(geom.x_step);
    assign yp = 33'(row_reg) * 33'(geom.y_step);
    assign xi = xp[32:16];
    assign yi = yp[32:16];

    always_comb
    begin
        xc  = (xi >= 17'(geom.sw)) ? geom.sw - 1'b1 : SW_BITS'(xi);
        yc  = (yi >= 17'(geom.sh)) ? geom.sh - 1'b1 : SH_BITS'(yi);
        xnc = (32'(xc) + 1 < 32'(geom.sw)) ? xc + 1'b1 : xc;
        ync = (32'(yc) + 1 < 32'(geom.sh)) ? yc + 1'b1 : yc;
    end

    logic store_ok;
    assign store_ok = (32'(col) < 32'(geom.sw)) && (32'(row) < 32'(geom.sh));
    logic [ADDR_BITS+1:0] store_addr;
    assign store_addr = (ADDR_BITS+2)'(row) * (ADDR_BITS+2)'(geom.sw)
                        + (ADDR_BITS+2)'(col);

    always_comb
    begin
        ram_we   = accept && operation == OP_STORE && store_ok;
        ram_addr = ADDR_BITS'(store_addr);
        case (state_reg)
            ST_RD1:  ram_addr = ADDR_BITS'(base0_reg + (ADDR_BITS+2)'(x_reg));
            ST_RD2:  ram_addr = ADDR_BITS'(base0_reg + (ADDR_BITS+2)'(xn_reg));
            ST_RD3:  ram_addr = ADDR_BITS'(base1_reg + (ADDR_BITS+2)'(x_reg));
            ST_RD4:  ram_addr = ADDR_BITS'(base1_reg + (ADDR_BITS+2)'(xn_reg));
            default: ;
        endcase
    end

    rbs_frame_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pixel_in),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && operation == OP_PRODUCE)
                    state_next = ST_COORD;
            ST_COORD:
                if (32'(col_reg) >= 32'(geom.dw) || 32'(row_reg) >= 32'(geom.dh))
                    state_next = ST_DONE;
                else
                    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = ST_RD3;
            ST_RD3:    state_next = ST_RD4;
            ST_RD4:    state_next = ST_BLEND1;
            ST_BLEND1: state_next = ST_BLEND2;
            ST_BLEND2: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
        end
    end

    // Horizontal blend of one channel pair: a*(256-w) + b*w.
    function automatic logic [13:0] hmix(input logic [5:0] a, input logic [5:0] b,
                                         input logic [7:0] w);
        logic [8:0] wi;
        wi = 9'd256 - 9'(w);
        return 14'(a) * 14'(wi) + 14'(b) * 14'(w);
    endfunction

    function automatic logic [5:0] vmix(input logic [13:0] t, input logic [13:0] u,
                                        input logic [7:0] w);
        logic [8:0]  wi;
        logic [23:0] s;
        wi = 9'd256 - 9'(w);
        s  = 24'(t) * 24'(wi) + 24'(u) * 24'(w);
        return s[21:16];
    endfunction

    logic [5:0] r_o, g_o, b_o;
    assign r_o = vmix(14'(top_r_reg), 14'(bot_r_reg), yw_reg);
    assign g_o = vmix(top_g_reg, bot_g_reg, yw_reg);
    assign b_o = vmix(14'(top_b_reg), 14'(bot_b_reg), yw_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        case (state_reg)
            ST_COORD:
            begin
                oor_reg   <= (32'(col_reg) >= 32'(geom.dw)) ||
                             (32'(row_reg) >= 32'(geom.dh));
                x_reg     <= xc;
                xn_reg    <= xnc;
                base0_reg <= (ADDR_BITS+2)'(yc) * (ADDR_BITS+2)'(geom.sw);
                base1_reg <= (ADDR_BITS+2)'(ync) * (ADDR_BITS+2)'(geom.sw);
                xw_reg    <= xp[15:8];
                yw_reg    <= yp[15:8];
                pix_reg   <= '0;
            end
            ST_RD2: p1_reg <= ram_rdata;
            ST_RD3: p2_reg <= ram_rdata;
            ST_RD4: p3_reg <= ram_rdata;
            ST_BLEND1:
            begin
                // ram_rdata holds the fourth pixel here.
                top_r_reg <= 13'(hmix({1'b0, p1_reg[15:11]}, {1'b0, p2_reg[15:11]}, xw_reg));
                bot_r_reg <= 13'(hmix({1'b0, p3_reg[15:11]}, {1'b0, ram_rdata[15:11]}, xw_reg));
                top_g_reg <= hmix(p1_reg[10:5], p2_reg[10:5], xw_reg);
                bot_g_reg <= hmix(p3_reg[10:5], ram_rdata[10:5], xw_reg);
                top_b_reg <= 13'(hmix({1'b0, p1_reg[4:0]}, {1'b0, p2_reg[4:0]}, xw_reg));
                bot_b_reg <= 13'(hmix({1'b0, p3_reg[4:0]}, {1'b0, ram_rdata[4:0]}, xw_reg));
            end
            ST_BLEND2:
                pix_reg <= {r_o[4:0], g_o, b_o[4:0]};
            default: ;
        endcase
    end

    assign done         = done_reg;
    assign pixel_out    = oor_reg ? '0 : pix_reg;
    assign out_of_range = oor_reg;

    // No command is taken while a produce is in flight.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept)
        else $error("command accepted while busy");

    // A result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A result only follows the final step of a produce.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DONE))
        else $error("done without a finished produce");

endmodule

// ===== sv/rbs_step_div.sv =====
// ----------------------------------------------------------------------------
// rbs_step_div
// Configuration registers and a restoring divider for the 8.16 step ratios.
// ----------------------------------------------------------------------------
module rbs_step_div
    import rbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output geom_t                    geom
);

    localparam int NUM_BITS = SW_BITS + 16;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [8:0] src_w_reg, src_h_reg;
    logic [9:0] dst_w_reg, dst_h_reg;
    logic       run_reg;
    logic       axis_reg;   // 0 x step, 1 y step
    logic [CNT_BITS-1:0] cnt_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [DST_BITS:0]   rem_reg;
    logic [STEP_BITS-1:0] xs_reg, ys_reg;

    logic [SW_BITS-1:0]  sw, sh;
    logic [DST_BITS-1:0] dw, dh;
    logic [DST_BITS:0]   rem_shift;
    logic [DST_BITS:0]   divisor;

    always_comb
    begin
        if (src_w_reg == 9'd0) sw = SW_BITS'(1);
        else if (32'(src_w_reg) > MAX_SRC_W) sw = SW_BITS'(MAX_SRC_W);
        else sw = SW_BITS'(src_w_reg);
        if (src_h_reg == 9'd0) sh = SH_BITS'(1);
        else if (32'(src_h_reg) > MAX_SRC_H) sh = SH_BITS'(MAX_SRC_H);
        else sh = SH_BITS'(src_h_reg);
        if (dst_w_reg == 10'd0) dw = DST_BITS'(1);
        else if (32'(dst_w_reg) > MAX_DST) dw = DST_BITS'(MAX_DST);
        else dw = DST_BITS'(dst_w_reg);
        if (dst_h_reg == 10'd0) dh = DST_BITS'(1);
        else if (32'(dst_h_reg) > MAX_DST) dh = DST_BITS'(MAX_DST);
        else dh = DST_BITS'(dst_h_reg);
    end

    assign divisor   = axis_reg ? {1'b0, dh} : {1'b0, dw};
    assign rem_shift = {rem_reg[DST_BITS-1:0], num_reg[NUM_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= 9'd160;
            src_h_reg <= 9'd120;
            dst_w_reg <= 10'd320;
            dst_h_reg <= 10'd240;
            run_reg   <= 1'b1;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
            quo_reg   <= '0;
            num_reg   <= '0;
            rem_reg   <= '0;
            xs_reg    <= '0;
            ys_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg <= cfg_data[8:0];
                REG_SRC_HEIGHT: src_h_reg <= cfg_data[8:0];
                REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                default: ;
            endcase
            run_reg  <= 1'b1;
            axis_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                // Load numerator (size - 1) << 16.
                num_reg <= axis_reg ? {SW_BITS'(sh - 1'b1), 16'd0}
                                    : {SW_BITS'(sw - 1'b1), 16'd0};
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                num_reg <= num_reg << 1;
                if (rem_shift >= divisor)
                begin
                    rem_reg <= rem_shift - divisor;
                    quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b0};
                end
                if (32'(cnt_reg) == NUM_BITS)
                begin
                    cnt_reg <= '0;
                    if (axis_reg)
                    begin
                        ys_reg  <= STEP_BITS'(rem_shift >= divisor ?
                                   {quo_reg[NUM_BITS-2:0], 1'b1} :
                                   {quo_reg[NUM_BITS-2:0], 1'b0});
                        run_reg <= 1'b0;
                    end
                    else
                    begin
                        xs_reg <= STEP_BITS'(rem_shift >= divisor ?
                                  {quo_reg[NUM_BITS-2:0], 1'b1} :
                                  {quo_reg[NUM_BITS-2:0], 1'b0});
                    end
                    axis_reg <= ~axis_reg;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign geom.sw       = sw;
    assign geom.sh       = sh;
    assign geom.dw       = dw;
    assign geom.dh       = dh;
    assign geom.x_step   = xs_reg;
    assign geom.y_step   = ys_reg;
    assign geom.steps_ok = ~run_reg;

endmodule

// ===== sv/rbs_frame_ram.sv =====
// ----------------------------------------------------------------------------
// rbs_frame_ram
// Single-port frame store with a registered read.
// ----------------------------------------------------------------------------
module rbs_frame_ram
    import rbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_BITS-1:0]  addr,
    input  logic [PIXEL_BITS-1:0] wdata,
    output logic [PIXEL_BITS-1:0] rdata
);

    logic [PIXEL_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule
